FILE: src/tcps_pkg.sv
// ----------------------------------------------------------------------------
// tcps_pkg
// shared types, constants and glyph decode for the text cell pixel serializer
// ----------------------------------------------------------------------------
package tcps_pkg;

  localparam int unsigned CODE_W    = 8;
  localparam int unsigned ROW_W     = 3;
  localparam int unsigned GLYPH_W   = 8;
  localparam int unsigned CELL_W    = 7;
  localparam int unsigned PAIR_W    = 2 * CELL_W;
  localparam int unsigned PIXEL_W   = 16;
  localparam int unsigned GLYPH_AW  = CODE_W + ROW_W;
  localparam int unsigned BEATS     = CELL_W;
  localparam int unsigned BEAT_CW   = $clog2(BEATS);
  localparam int unsigned IN_DATA_W = 40;
  localparam int unsigned CFG_AW    = 3;
  localparam int unsigned CFG_DW    = 32;

  localparam logic [GLYPH_W-1:0] NORMAL_BIT = 8'h80;
  localparam logic [CELL_W-1:0]  CELL_MASK  = 7'h7f;
  localparam logic [BEAT_CW-1:0] LAST_BEAT  = BEAT_CW'(BEATS - 1);

  typedef enum logic {
    REG_FORE = 1'b0,
    REG_BACK = 1'b1
  } reg_idx_t;

  typedef enum logic {
    MODE_LOAD   = 1'b0,
    MODE_RENDER = 1'b1
  } mode_t;

  typedef struct packed {
    logic              valid;
    logic [PAIR_W-1:0] bits;
  } shift_load_t;

  function automatic logic [CELL_W-1:0] cell_bits(
    input logic               code_normal,
    input logic [GLYPH_W-1:0] glyph,
    input logic [CELL_W-1:0]  mask
  );
    logic [CELL_W-1:0] low;
    low = glyph[CELL_W-1:0];
    if (code_normal) begin
      return low;
    end else if ((glyph & NORMAL_BIT) == '0) begin
      return low ^ CELL_MASK;
    end else begin
      return low ^ mask;
    end
  endfunction

endpackage

FILE: src/tcps_ram.sv
// ----------------------------------------------------------------------------
// tcps_ram
// generic single-port-write, single-port-read ram with registered read
// ----------------------------------------------------------------------------
module tcps_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: src/tcps_shifter.sv
// ----------------------------------------------------------------------------
// tcps_shifter
// shifts a 14-bit cell pair out msb first as seven pixel-pair beats
// ----------------------------------------------------------------------------
module tcps_shifter (
  input  logic                            clk,
  input  logic                            rst_n,
  input  tcps_pkg::shift_load_t           ld,
  output logic                            ld_ready,
  input  logic [tcps_pkg::PIXEL_W-1:0]    fore_color,
  input  logic [tcps_pkg::PIXEL_W-1:0]    back_color,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [2*tcps_pkg::PIXEL_W-1:0]  out_tdata,
  output logic                            out_tlast
);
  import tcps_pkg::*;

  logic              busy_r, busy_nxt;
  logic [BEAT_CW-1:0] cnt_r, cnt_nxt;
  logic [PAIR_W-1:0] bits_r, bits_nxt;
  logic              fire, done, take;

  assign fire     = busy_r && out_tready;
  assign done     = fire && (cnt_r == LAST_BEAT);
  assign ld_ready = !busy_r || done;
  assign take     = ld.valid && ld_ready;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    bits_nxt = bits_r;
    if (take) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      bits_nxt = ld.bits;
    end else if (done) begin
      busy_nxt = 1'b0;
      cnt_nxt  = '0;
    end else if (fire) begin
      cnt_nxt  = cnt_r + 1'b1;
      bits_nxt = {bits_r[PAIR_W-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    bits_r <= bits_nxt;
  end

  assign out_tvalid = busy_r;
  assign out_tlast  = (cnt_r == LAST_BEAT);
  assign out_tdata  = {bits_r[PAIR_W-2] ? fore_color : back_color,
                       bits_r[PAIR_W-1] ? fore_color : back_color};

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= LAST_BEAT) else $error("beat count past last beat");

  a_done_restart: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> (cnt_r == '0)) else $error("beat count not restarted after last beat");
`endif

endmodule

FILE: src/text_cell_pixel_serializer.sv
// ----------------------------------------------------------------------------
// text_cell_pixel_serializer
// text-mode character generator: glyph store load and two-cell pixel output
//
//   channel  dir  beat                          handshake
//   in_      in   load glyph byte / render pair  tvalid/tready
//   out_     out  pixel pair, tlast on 7th       tvalid/tready
//   cfg_     in   fore/back color registers      apb, pready high
//
// a render beat gives 7 output beats, one a cycle while out_tready is high,
// so the render rate is set by the output shifter
// glyph lookup is a registered read of two mirrored 2048x8 rams (one per cell)
// one render waits in the lookup stage while the shifter drains the previous
// synchronous active-low reset clears control state; the glyph store is not
// cleared and must be loaded before use
// ----------------------------------------------------------------------------
module text_cell_pixel_serializer (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // char_a[7:0], char_b[15:8], glyph_row[18:16], rom_data[26:19],
  // flash_mask[33:27], zero pad
  input  logic [tcps_pkg::IN_DATA_W-1:0]    in_tdata,
  // mode
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // left_pixel[15:0], right_pixel[31:16]
  output logic [2*tcps_pkg::PIXEL_W-1:0]    out_tdata,
  output logic                              out_tlast,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [tcps_pkg::CFG_AW-1:0]       cfg_paddr,
  input  logic [tcps_pkg::CFG_DW-1:0]       cfg_pwdata,
  output logic [tcps_pkg::CFG_DW-1:0]       cfg_prdata,
  output logic                              cfg_pready
);
  import tcps_pkg::*;

  logic [CODE_W-1:0]  char_a, char_b;
  logic [ROW_W-1:0]   glyph_row;
  logic [GLYPH_W-1:0] rom_data;
  logic [CELL_W-1:0]  flash_mask;

  assign char_a     = in_tdata[7:0];
  assign char_b     = in_tdata[15:8];
  assign glyph_row  = in_tdata[18:16];
  assign rom_data   = in_tdata[26:19];
  assign flash_mask = in_tdata[33:27];

  logic [PIXEL_W-1:0] fore_r, back_r;
  logic               cfg_wr;
  reg_idx_t           cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fore_r <= '1;
      back_r <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_FORE: fore_r <= cfg_pwdata[PIXEL_W-1:0];
        REG_BACK: back_r <= cfg_pwdata[PIXEL_W-1:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_FORE: cfg_prdata = CFG_DW'(fore_r);
      REG_BACK: cfg_prdata = CFG_DW'(back_r);
      default:  cfg_prdata = '0;
    endcase
  end

  logic               in_fire, ram_we, ram_re;
  logic [GLYPH_AW-1:0] addr_a, addr_b;
  logic [GLYPH_W-1:0] glyph_a, glyph_b;

  assign in_fire = in_tvalid && in_tready;
  assign ram_we  = in_fire && (mode_t'(in_tuser) == MODE_LOAD);
  assign ram_re  = in_fire && (mode_t'(in_tuser) == MODE_RENDER);
  assign addr_a  = {char_a, glyph_row};
  assign addr_b  = {char_b, glyph_row};

  tcps_ram #(.WIDTH(GLYPH_W), .DEPTH(1 << GLYPH_AW)) u_ram_a (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr_a),
    .wdata (rom_data),
    .re    (ram_re),
    .raddr (addr_a),
    .rdata (glyph_a)
  );

  tcps_ram #(.WIDTH(GLYPH_W), .DEPTH(1 << GLYPH_AW)) u_ram_b (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr_a),
    .wdata (rom_data),
    .re    (ram_re),
    .raddr (addr_b),
    .rdata (glyph_b)
  );

  logic              s1_valid_r, s1_valid_nxt;
  logic              s1_norm_a_r, s1_norm_b_r;
  logic [CELL_W-1:0] s1_mask_r;
  shift_load_t       ld;
  logic              ld_ready;

  assign ld.valid  = s1_valid_r;
  assign ld.bits   = {cell_bits(s1_norm_a_r, glyph_a, s1_mask_r),
                      cell_bits(s1_norm_b_r, glyph_b, s1_mask_r)};
  assign in_tready = !s1_valid_r || ld_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = ram_re;
    end else if (ld_ready) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
    if (ram_re) begin
      s1_norm_a_r <= char_a[CODE_W-1];
      s1_norm_b_r <= char_b[CODE_W-1];
      s1_mask_r   <= flash_mask;
    end
  end

  tcps_shifter u_shifter (
    .clk        (clk),
    .rst_n      (rst_n),
    .ld         (ld),
    .ld_ready   (ld_ready),
    .fore_color (fore_r),
    .back_color (back_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

`ifndef NO_ASSERTIONS
  a_rw_excl: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({ram_we, ram_re})) else $error("glyph load and lookup in one cycle");

  a_render_staged: assert property (@(posedge clk) disable iff (!rst_n)
    ram_re |=> s1_valid_r) else $error("render beat lost after lookup");

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !ld_ready) |=> (s1_valid_r && $stable(glyph_a) && $stable(glyph_b)))
    else $error("stalled lookup stage changed");
`endif

endmodule
